FILE: design/http_request_stream_framer_unit_macros.svh
// assertion macros shared by the framer rtl
`ifndef HTTP_REQUEST_STREAM_FRAMER_UNIT_MACROS_SVH
`define HTTP_REQUEST_STREAM_FRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define HRSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hrsf_pkg.sv
// shared constants and code points of the http request stream framer
package hrsf_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 32;
  localparam int unsigned BODY_LENGTH_W = 32;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [2:0] ROLE_METHOD  = 3'd0;
  localparam logic [2:0] ROLE_URI     = 3'd1;
  localparam logic [2:0] ROLE_VERSION = 3'd2;
  localparam logic [2:0] ROLE_HNAME   = 3'd3;
  localparam logic [2:0] ROLE_HVALUE  = 3'd4;
  localparam logic [2:0] ROLE_BODY    = 3'd5;
  localparam logic [2:0] ROLE_DELIM   = 3'd6;
  localparam logic [2:0] ROLE_IGNORED = 3'd7;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // "HTTP/1." then the minor digit is checked separately
  localparam logic [7:0] VERSION_TEXT [7] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E};
  localparam int unsigned VERSION_LEN = 8;

  // "Content-Length"
  localparam logic [7:0] KEY_TEXT [14] = '{8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
                                           8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68};
  localparam int unsigned KEY_LEN = 14;

endpackage

FILE: design/hrsf_if.sv
// stream byte and label channel interfaces
interface hrsf_in_if import hrsf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface hrsf_out_if import hrsf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               field_role;
  logic                     cr_was_data;
  logic                     request_done;
  logic [BODY_LENGTH_W-1:0] body_length;
  logic                     parse_error;

  modport source (output valid, output field_role, output cr_was_data, output request_done,
                  output body_length, output parse_error, input ready);
  modport sink   (input valid, input field_role, input cr_was_data, input request_done,
                  input body_length, input parse_error, output ready);
endinterface

FILE: design/http_request_stream_framer_unit.sv
// http request stream framer: labels each stream byte with its request role
//
//   channel  dir  payload
//   stream   in   op, data_byte
//   labels   out  field_role, cr_was_data, request_done, body_length, parse_error
//
// one byte per clock unless labels stalls; the label of an accepted byte is
// registered with the parser state update and shows in the cycle after acceptance
// rst (synchronous) puts the parser in the method phase and empties the result register
// labels stalled: the result holds, and stream takes a beat only if the result is leaving
`include "http_request_stream_framer_unit_macros.svh"

module http_request_stream_framer_unit
  import hrsf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  hrsf_in_if.sink     stream,
  hrsf_out_if.source  labels
);

  localparam int unsigned LB = LENGTH_BITS;

  typedef enum logic [3:0] {
    PH_METHOD, PH_URI, PH_VERSION, PH_HSTART, PH_HNAME,
    PH_HSKIP, PH_HVALUE, PH_BODY, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {DG_NONE, DG_IN, DG_END, DG_BAD} digits_t;

  typedef struct packed {
    phase_t         phase;
    logic           cr_pend;
    logic [3:0]     ver_pos;
    logic           ver_bad;
    logic [3:0]     key_pos;
    logic           key_bad;
    logic [LB-1:0]  acc;
    digits_t        digits;
    logic           have_len;
    logic [LB-1:0]  body_rem;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic [2:0] role;
  } absorb_t;

  typedef struct packed {
    st_t  st;
    logic done;
  } line_t;

  function automatic st_t reset_st();
    st_t s;
    s = '0;
    s.phase  = PH_METHOD;
    s.digits = DG_NONE;
    return s;
  endfunction

  function automatic logic key_is_length(st_t s);
    return !s.key_bad && s.key_pos == 4'(KEY_LEN);
  endfunction

  function automatic st_t length_byte(st_t s, logic [7:0] b);
    logic [LB+3:0] ext;
    ext = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {{LB{1'b0}}, b[3:0]};
    if (b >= CH_ZERO && b <= CH_NINE) begin
      if (s.digits == DG_NONE || s.digits == DG_IN) begin
        // anything above the top bits means the value no longer fits
        if (ext[LB+3:LB] != 4'd0) begin
          s.digits = DG_BAD;
        end else begin
          s.acc    = ext[LB-1:0];
          s.digits = DG_IN;
        end
      end
    end else if (s.digits == DG_NONE) begin
      s.digits = DG_BAD;
    end else if (s.digits == DG_IN) begin
      s.digits = DG_END;
    end
    return s;
  endfunction

  function automatic absorb_t absorb(st_t s, logic [7:0] b);
    absorb_t r;
    r.st   = s;
    r.role = ROLE_IGNORED;
    case (s.phase)
      PH_METHOD: begin
        if (b == CH_SP) begin
          r.st.phase = PH_URI;
          r.role     = ROLE_DELIM;
        end else begin
          r.role = ROLE_METHOD;
        end
      end
      PH_URI: begin
        if (b == CH_SP) begin
          r.st.phase = PH_VERSION;
          r.role     = ROLE_DELIM;
        end else begin
          r.role = ROLE_URI;
        end
      end
      PH_VERSION: begin
        if (s.ver_pos < 4'd7) begin
          if (b != VERSION_TEXT[s.ver_pos[2:0]]) r.st.ver_bad = 1'b1;
        end else if (s.ver_pos == 4'd7) begin
          if (b != CH_ZERO && b != CH_ONE) r.st.ver_bad = 1'b1;
        end else begin
          r.st.ver_bad = 1'b1;
        end
        if (s.ver_pos != 4'hF) r.st.ver_pos = s.ver_pos + 4'd1;
        r.role = ROLE_VERSION;
      end
      PH_HSTART, PH_HNAME: begin
        r.st.phase = PH_HNAME;
        if (b == CH_COLON) begin
          r.st.phase = PH_HSKIP;
          if (key_is_length(s)) begin
            // a repeated key restarts the value
            r.st.have_len = 1'b1;
            r.st.acc      = '0;
            r.st.digits   = DG_NONE;
          end
          r.role = ROLE_DELIM;
        end else begin
          if (s.key_pos < 4'(KEY_LEN)) begin
            if (b != KEY_TEXT[s.key_pos]) r.st.key_bad = 1'b1;
          end else begin
            r.st.key_bad = 1'b1;
          end
          if (s.key_pos != 4'hF) r.st.key_pos = s.key_pos + 4'd1;
          r.role = ROLE_HNAME;
        end
      end
      PH_HSKIP: begin
        if (b == CH_SP) begin
          r.role = ROLE_DELIM;
        end else begin
          r.st.phase = PH_HVALUE;
          if (key_is_length(s)) r.st = length_byte(r.st, b);
          r.role = ROLE_HVALUE;
        end
      end
      PH_HVALUE: begin
        if (key_is_length(s)) r.st = length_byte(r.st, b);
        r.role = ROLE_HVALUE;
      end
      default: r.role = ROLE_IGNORED;
    endcase
    return r;
  endfunction

  function automatic line_t end_line(st_t s);
    line_t r;
    r.st   = s;
    r.done = 1'b0;
    case (s.phase)
      PH_VERSION: begin
        if (!s.ver_bad && s.ver_pos == 4'(VERSION_LEN)) begin
          r.st.phase   = PH_HSTART;
          r.st.key_pos = '0;
          r.st.key_bad = 1'b0;
        end else begin
          r.st.phase = PH_ERROR;
        end
      end
      PH_HSKIP, PH_HVALUE: begin
        r.st.phase   = PH_HSTART;
        r.st.key_pos = '0;
        r.st.key_bad = 1'b0;
      end
      PH_HSTART: begin
        // empty line closes the headers
        if (!s.have_len) begin
          r.st.acc = '0;
          r.done   = 1'b1;
        end else if (s.digits == DG_NONE || s.digits == DG_BAD) begin
          r.st.phase = PH_ERROR;
        end else if (s.acc == '0) begin
          r.done = 1'b1;
        end else begin
          r.st.body_rem = s.acc;
          r.st.phase    = PH_BODY;
        end
      end
      default: r.st.phase = PH_ERROR;
    endcase
    return r;
  endfunction

  st_t st;
  st_t st_next;

  logic                     accept;
  logic [2:0]               role_next;
  logic                     crdata_next;
  logic                     done_next;
  logic [BODY_LENGTH_W-1:0] blen_next;

  assign stream.ready = !labels.valid || labels.ready;
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    st_t     cur;
    absorb_t ab;
    line_t   ln;
    logic    line_end;
    logic [63:0] acc_wide;
    cur         = st;
    ab          = '0;
    ln          = '0;
    line_end    = 1'b0;
    acc_wide    = '0;
    role_next   = ROLE_IGNORED;
    crdata_next = 1'b0;
    done_next   = 1'b0;
    blen_next   = '0;
    if (stream.op == OP_CLEAR) begin
      cur = reset_st();
    end else begin
      case (st.phase)
        PH_BODY: begin
          role_next = ROLE_BODY;
          if (cur.body_rem != '0) cur.body_rem = cur.body_rem - LB'(1);
          if (cur.body_rem == '0) done_next = 1'b1;
        end
        PH_METHOD, PH_URI, PH_VERSION, PH_HSTART, PH_HNAME, PH_HSKIP, PH_HVALUE: begin
          if (cur.cr_pend) begin
            cur.cr_pend = 1'b0;
            if (stream.data_byte == CH_LF) begin
              line_end  = 1'b1;
              role_next = ROLE_DELIM;
              ln        = end_line(cur);
              cur       = ln.st;
              done_next = ln.done;
            end else begin
              // held cr turns out to be field data
              crdata_next = 1'b1;
              ab          = absorb(cur, CH_CR);
              cur         = ab.st;
            end
          end
          if (!line_end) begin
            if (stream.data_byte == CH_CR) begin
              cur.cr_pend = 1'b1;
              role_next   = ROLE_DELIM;
            end else begin
              ab        = absorb(cur, stream.data_byte);
              cur       = ab.st;
              role_next = ab.role;
            end
          end
        end
        default: cur.phase = PH_ERROR;
      endcase
    end
    if (done_next) begin
      acc_wide  = 64'(cur.acc);
      blen_next = acc_wide[BODY_LENGTH_W-1:0];
      cur       = reset_st();
    end
    st_next = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= reset_st();
      labels.valid <= 1'b0;
    end else begin
      if (accept) begin
        st           <= st_next;
        labels.valid <= 1'b1;
      end else if (labels.ready) begin
        labels.valid <= 1'b0;
      end
    end
    if (accept) begin
      labels.field_role   <= role_next;
      labels.cr_was_data  <= crdata_next;
      labels.request_done <= done_next;
      labels.body_length  <= blen_next;
      labels.parse_error  <= (st_next.phase == PH_ERROR);
    end
  end

  `HRSF_ASSERT_NEXT(a_clear_restarts, clk, rst, accept && stream.op == OP_CLEAR, st.phase == PH_METHOD && !st.cr_pend && !labels.parse_error, "clear beat did not restart the parser")
  `HRSF_ASSERT_NEXT(a_error_sticks, clk, rst, accept && stream.op == OP_BYTE && st.phase == PH_ERROR, labels.parse_error && labels.field_role == ROLE_IGNORED, "error phase left without a clear")
  `HRSF_ASSERT_NOW(a_length_only_when_done, clk, rst, labels.valid && !labels.request_done, labels.body_length == '0, "body length shown without request completion")
  `HRSF_ASSERT_NOW(a_done_without_error, clk, rst, labels.valid && labels.request_done, !labels.parse_error && (labels.field_role == ROLE_BODY || labels.field_role == ROLE_DELIM), "request completed on an unexpected byte")

endmodule
